FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif
`endif

FILE: sv/mvf_pkg.sv
package mvf_pkg;

    localparam int MAX_DIM     = 128;
    localparam int VALUE_WIDTH = 16;
    localparam int TDATA_W     = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int MODE_W      = 3;
    localparam int IDX_W       = $clog2(MAX_DIM);
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int CMP_W       = (DIM_W > CFG_W) ? DIM_W : CFG_W;
    localparam int MAG_W       = VALUE_WIDTH - 1;
    localparam int DIV_W       = VALUE_WIDTH / 2 + 1;
    localparam int SQ_W        = VALUE_WIDTH + 1;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FULL      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CORNERS   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BORDER    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DIAGONALS = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PRIMES    = 3'd4;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BL = 2'd2;
    localparam logic [1:0] CORNER_BR = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIME,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PR_IDLE,
        PR_CHECK,
        PR_DIV,
        PR_DONE
    } t_prime_state;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_div_status;

    typedef struct packed {
        logic done;
        logic is_prime;
    } t_prime_status;

    // Maps a written dimension to its last index, with zero acting as one
    // and anything above the maximum acting as the maximum.
    function automatic logic [IDX_W-1:0] clamp_last(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] ext;
        ext = CMP_W'(v);
        if (ext == '0) begin
            return '0;
        end else if (ext > CMP_W'(MAX_DIM)) begin
            return IDX_W'(MAX_DIM - 1);
        end else begin
            return IDX_W'(ext - CMP_W'(1));
        end
    endfunction

endpackage

FILE: sv/mvf_divider.sv
module mvf_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mvf_pkg::MAG_W-1:0] i_dividend,
    input  logic [mvf_pkg::DIV_W-1:0] i_divisor,
    output mvf_pkg::t_div_status      o_status
);
    import mvf_pkg::*;

    // Restoring remainder, one dividend bit per cycle from the top down.
    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0] r_shift;
    logic [DIV_W-1:0] r_divisor;
    logic [DIV_W:0]   r_rem;
    logic [DIV_W:0]   n_rem;
    logic [DIV_W:0]   w_trial;

    always_comb begin
        w_trial = {r_rem[DIV_W-1:0], r_shift[MAG_W-1]};
        if (w_trial >= {1'b0, r_divisor}) begin
            n_rem = w_trial - {1'b0, r_divisor};
        end else begin
            n_rem = w_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift   <= i_dividend;
            r_divisor <= i_divisor;
            r_rem     <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[MAG_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_status.done     = r_done;
    assign o_status.rem_zero = (r_rem == '0);

endmodule

FILE: sv/mvf_prime.sv
module mvf_prime (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [mvf_pkg::VALUE_WIDTH-1:0] i_value,
    output mvf_pkg::t_prime_status          o_status
);
    import mvf_pkg::*;

    t_prime_state     r_state;
    t_prime_state     n_state;
    logic [MAG_W-1:0] r_mag;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] n_div;
    logic [SQ_W-1:0]  r_sq;
    logic [SQ_W-1:0]  n_sq;
    logic             r_result;
    logic             n_result;
    logic             w_small;
    logic             w_div_start;
    t_div_status      w_div_status;

    mvf_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_div),
        .o_status   (w_div_status)
    );

    assign w_small = i_value[VALUE_WIDTH-1] || (i_value < VALUE_WIDTH'(2));

    // The square of the divisor is kept alongside it and stepped by 2d + 1.
    always_comb begin
        n_state     = r_state;
        n_div       = r_div;
        n_sq        = r_sq;
        n_result    = r_result;
        w_div_start = 1'b0;
        case (r_state)
            PR_IDLE: begin
                if (i_start) begin
                    n_div = DIV_W'(2);
                    n_sq  = SQ_W'(4);
                    if (w_small) begin
                        n_result = 1'b0;
                        n_state  = PR_DONE;
                    end else begin
                        n_state = PR_CHECK;
                    end
                end
            end
            PR_CHECK: begin
                if (r_sq > SQ_W'(r_mag)) begin
                    n_result = 1'b1;
                    n_state  = PR_DONE;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = PR_DIV;
                end
            end
            PR_DIV: begin
                if (w_div_status.done) begin
                    if (w_div_status.rem_zero) begin
                        n_result = 1'b0;
                        n_state  = PR_DONE;
                    end else begin
                        n_div   = r_div + DIV_W'(1);
                        n_sq    = r_sq + SQ_W'({r_div, 1'b1});
                        n_state = PR_CHECK;
                    end
                end
            end
            PR_DONE: begin
                n_state = PR_IDLE;
            end
            default: begin
                n_state = PR_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div    <= n_div;
        r_sq     <= n_sq;
        r_result <= n_result;
        if (r_state == PR_IDLE && i_start) begin
            r_mag <= i_value[MAG_W-1:0];
        end
    end

    assign o_status.done     = (r_state == PR_DONE);
    assign o_status.is_prime = r_result;

endmodule

FILE: sv/matrix_view_filter_with_prime_test.sv
// Channel   Direction  Signals                       Contents
// s_axis    in         tvalid tready tdata[15:0]     element_value
// m_axis    out        tvalid tready tdata[15:0]     out_value
//                      tuser[0] tlast                row_end, last
// cfg       in         i_cfg_we i_cfg_index i_cfg_data  num_rows, num_cols, mode
//
// One word is taken at a time; s_axis_tready is high only while nothing is pending.
// Full, border and diagonal views register each word and hold it until its handshake out.
// The primes view runs trial division on a bit-serial remainder unit, trying one
// divisor at a time until its square exceeds the word.
// A corner word holds up to four results in the output register, one per handshake.
// Reset is synchronous and active low; output stalls simply hold the block.
`include "assert_macros.svh"

module matrix_view_filter_with_prime_test (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [mvf_pkg::TDATA_W-1:0]        s_axis_tdata,   // element_value
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [mvf_pkg::TDATA_W-1:0]        m_axis_tdata,   // out_value
    output logic [0:0]                         m_axis_tuser,   // row_end
    output logic                               m_axis_tlast,
    input  logic                               i_cfg_we,
    input  logic [mvf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mvf_pkg::CFG_W-1:0]          i_cfg_data
);
    import mvf_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    logic [CFG_W-1:0]       r_num_rows;
    logic [CFG_W-1:0]       r_num_cols;
    logic [MODE_W-1:0]      r_mode;
    logic [IDX_W-1:0]       r_row;
    logic [IDX_W-1:0]       n_row;
    logic [IDX_W-1:0]       r_col;
    logic [IDX_W-1:0]       n_col;
    logic [3:0]             r_pend;
    logic [3:0]             n_pend;
    logic                   r_single;
    logic                   n_single;
    logic                   r_row_end;
    logic                   n_row_end;
    logic                   r_last;
    logic                   n_last;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;

    logic [IDX_W-1:0]       w_rows_last;
    logic [IDX_W-1:0]       w_cols_last;
    logic [VALUE_WIDTH-1:0] w_in;
    logic                   w_last_col;
    logic                   w_last_row;
    logic                   w_top;
    logic                   w_bottom;
    logic                   w_left;
    logic                   w_right;
    logic                   w_diag;
    logic                   w_keep;
    logic                   w_accept;
    logic                   w_out_hs;
    logic                   w_prime_start;
    logic [1:0]             w_corner;
    t_prime_status          w_prime_status;

    mvf_prime u_prime (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_prime_start),
        .i_value  (w_in),
        .o_status (w_prime_status)
    );

    assign w_rows_last = clamp_last(r_num_rows);
    assign w_cols_last = clamp_last(r_num_cols);
    assign w_in        = s_axis_tdata[VALUE_WIDTH-1:0];
    assign w_last_col  = (r_col >= w_cols_last);
    assign w_last_row  = (r_row >= w_rows_last);
    assign w_top       = (r_row == '0);
    assign w_bottom    = (r_row == w_rows_last);
    assign w_left      = (r_col == '0);
    assign w_right     = (r_col == w_cols_last);
    assign w_diag      = (r_row == r_col)
                      || (({1'b0, r_row} + {1'b0, r_col}) == {1'b0, w_cols_last});
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_out_hs    = m_axis_tvalid && m_axis_tready;

    always_comb begin
        if (r_pend[0]) begin
            w_corner = CORNER_TL;
        end else if (r_pend[1]) begin
            w_corner = CORNER_TR;
        end else if (r_pend[2]) begin
            w_corner = CORNER_BL;
        end else begin
            w_corner = CORNER_BR;
        end
    end

    always_comb begin
        case (r_mode)
            MODE_BORDER:    w_keep = w_top || w_last_row || w_left || w_last_col;
            MODE_DIAGONALS: w_keep = w_diag;
            default:        w_keep = 1'b1;
        endcase
    end

    always_comb begin
        n_state       = r_state;
        n_row         = r_row;
        n_col         = r_col;
        n_pend        = r_pend;
        n_single      = r_single;
        n_row_end     = r_row_end;
        n_last        = r_last;
        n_value       = r_value;
        s_axis_tready = 1'b0;
        w_prime_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_accept) begin
                    if (w_last_col) begin
                        n_col = '0;
                        n_row = w_last_row ? '0 : r_row + IDX_W'(1);
                    end else begin
                        n_col = r_col + IDX_W'(1);
                    end
                    n_row_end = w_last_col;
                    n_last    = w_last_col && w_last_row;
                    n_value   = w_in;
                    case (r_mode)
                        MODE_CORNERS: begin
                            n_single = 1'b0;
                            n_pend   = {w_bottom && w_right, w_bottom && w_left,
                                        w_top && w_right, w_top && w_left};
                            n_state  = (w_top || w_bottom) && (w_left || w_right)
                                     ? ST_EMIT : ST_IDLE;
                        end
                        MODE_PRIMES: begin
                            n_single      = 1'b1;
                            w_prime_start = 1'b1;
                            n_state       = ST_PRIME;
                        end
                        default: begin
                            n_single = 1'b1;
                            n_pend   = 4'b0001;
                            n_value  = w_keep ? w_in : '0;
                            n_state  = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_PRIME: begin
                if (w_prime_status.done) begin
                    n_pend  = 4'b0001;
                    n_value = w_prime_status.is_prime ? r_value : '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_hs) begin
                    n_pend = r_pend & (r_pend - 4'd1);
                    if ((r_pend & (r_pend - 4'd1)) == 4'd0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_row      <= '0;
            r_col      <= '0;
            r_pend     <= '0;
            r_num_rows <= CFG_W'(1);
            r_num_cols <= CFG_W'(1);
            r_mode     <= MODE_FULL;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_pend  <= n_pend;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                    CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                    CFG_MODE:     r_mode     <= i_cfg_data[MODE_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_single  <= n_single;
        r_row_end <= n_row_end;
        r_last    <= n_last;
        r_value   <= n_value;
    end

    assign m_axis_tvalid   = (r_state == ST_EMIT);
    assign m_axis_tdata    = TDATA_W'(r_value);
    assign m_axis_tuser[0] = r_single ? r_row_end
                           : ((w_corner == CORNER_TR) || (w_corner == CORNER_BR));
    assign m_axis_tlast    = r_single ? r_last : (w_corner == CORNER_BR);

    `ASSERT_IMPLY(a_emit_has_pending, i_clk, i_rst_n, m_axis_tvalid, r_pend != 4'd0)
    `ASSERT_IMPLY(a_last_closes_row, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0])
    `ASSERT_IMPLY(a_prime_only_waited, i_clk, i_rst_n, w_prime_status.done, r_state == ST_PRIME)
    `ASSERT_NEXT(a_prime_start_waits, i_clk, i_rst_n, w_prime_start, r_state == ST_PRIME)

endmodule
